/* hdl/tsi_pkg.sv */
// Shared types, codes and character helpers for the text to signed integer parser.
package tsi_pkg;

  localparam int CHAR_W   = 8;
  localparam int RADIX_W  = 6;
  localparam int VALUE_W  = 64;
  localparam int END_W    = 13;
  localparam int STATUS_W = 2;
  localparam int DIGIT_W  = 6;

  localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
  localparam logic [RADIX_W-1:0] RADIX_ONE   = 6'd1;
  localparam logic [RADIX_W-1:0] RADIX_OCT   = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [DIGIT_W-1:0] DIGIT_NONE  = 6'd63;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_HEXMARK,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_NO_DIGITS,
    ST_RANGE,
    ST_BAD_RADIX
  } status_t;

  typedef struct packed {
    phase_t phase;
    logic   negative;
    logic   overflowed;
    logic   seen_digit;
  } ctl_t;

  localparam ctl_t CTL_RESET = '{phase: PH_SPACE, negative: 1'b0,
                                 overflowed: 1'b0, seen_digit: 1'b0};

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] t;
    t = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      t = c - CH_LO_A + 8'd10;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      t = c - CH_UP_A + 8'd10;
    end else begin
      t = {2'b00, DIGIT_NONE};
    end
    return t[DIGIT_W-1:0];
  endfunction

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

  function automatic logic radix_bad(input logic [RADIX_W-1:0] r);
    return r == RADIX_ONE || r > RADIX_MAX;
  endfunction

endpackage

/* hdl/tsi_step.sv */
// Next parse state for one character and the result formed from that state.
module tsi_step #(
  parameter int MAX_CHARS  = 4096,
  parameter int VALUE_BITS = 64
) (
  input  logic [tsi_pkg::CHAR_W-1:0]   character,
  input  logic [tsi_pkg::RADIX_W-1:0]  radix,
  input  tsi_pkg::ctl_t                ctl,
  input  logic [VALUE_BITS-1:0]        acc,
  input  logic [tsi_pkg::RADIX_W-1:0]  base,
  input  logic [$clog2(MAX_CHARS+1)-1:0] pos,
  input  logic [$clog2(MAX_CHARS+1)-1:0] end_pos,
  output tsi_pkg::ctl_t                ctl_next,
  output logic [VALUE_BITS-1:0]        acc_next,
  output logic [tsi_pkg::RADIX_W-1:0]  base_next,
  output logic [$clog2(MAX_CHARS+1)-1:0] pos_next,
  output logic [$clog2(MAX_CHARS+1)-1:0] end_pos_next,
  output logic [tsi_pkg::VALUE_W-1:0]  res_value,
  output logic [tsi_pkg::END_W-1:0]    res_end,
  output logic [tsi_pkg::STATUS_W-1:0] res_status
);

  localparam int PW  = $clog2(MAX_CHARS+1);
  localparam int PRW = VALUE_BITS + tsi_pkg::RADIX_W;
  localparam int VW  = tsi_pkg::VALUE_W;
  localparam int EW  = tsi_pkg::END_W;
  localparam logic [PW-1:0] MAX_POS = PW'(MAX_CHARS);

  logic                        first;
  logic [tsi_pkg::RADIX_W-1:0] base_c;
  tsi_pkg::phase_t             ph;
  logic [tsi_pkg::RADIX_W-1:0] wb;
  logic [tsi_pkg::DIGIT_W-1:0] d;
  logic [PRW-1:0]              prod;
  logic [PRW-1:0]              lim;
  logic                        fits;
  logic [PW-1:0]               pos_inc;
  logic                        start_zero;
  logic                        hex_mark;
  logic                        take_path;
  logic signed [VALUE_BITS-1:0] val_s;
  logic [PW+EW-1:0]            end_wide;
  logic [VALUE_BITS-1:0]       top;

  assign first   = pos == '0;
  assign base_c  = first ? radix : base;
  assign ph      = (first && tsi_pkg::radix_bad(radix)) ? tsi_pkg::PH_DONE : ctl.phase;
  assign wb      = (base_c != tsi_pkg::RADIX_AUTO) ? base_c :
                   (ph == tsi_pkg::PH_ZERO) ? tsi_pkg::RADIX_OCT : tsi_pkg::RADIX_DEC;
  assign d       = tsi_pkg::digit_of(character);
  assign prod    = PRW'(acc) * PRW'(wb) + PRW'(d);
  assign lim     = (PRW'(1) << (VALUE_BITS-1)) - PRW'(!ctl.negative);
  assign fits    = prod <= lim;
  assign pos_inc = pos + PW'(1);
  assign start_zero = character == tsi_pkg::CH_ZERO;
  assign hex_mark   = (base_c == tsi_pkg::RADIX_AUTO || base_c == tsi_pkg::RADIX_HEX) &&
                      (character == tsi_pkg::CH_LO_X || character == tsi_pkg::CH_UP_X);

  always_comb begin
    ctl_next       = ctl;
    ctl_next.phase = ph;
    acc_next       = acc;
    base_next      = base_c;
    pos_next       = pos;
    end_pos_next   = end_pos;
    take_path      = 1'b0;
    if (pos < MAX_POS) begin
      pos_next = pos_inc;
      unique case (ph)
        tsi_pkg::PH_SPACE: begin
          if (tsi_pkg::is_blank(character)) begin
            take_path = 1'b0;
          end else if (character == tsi_pkg::CH_PLUS || character == tsi_pkg::CH_MINUS) begin
            ctl_next.negative = character == tsi_pkg::CH_MINUS;
            ctl_next.phase    = tsi_pkg::PH_SIGNED;
          end else if (start_zero) begin
            acc_next            = '0;
            ctl_next.seen_digit = 1'b1;
            end_pos_next        = pos_inc;
            ctl_next.phase      = tsi_pkg::PH_ZERO;
          end else begin
            take_path = 1'b1;
          end
        end
        tsi_pkg::PH_SIGNED: begin
          if (start_zero) begin
            acc_next            = '0;
            ctl_next.seen_digit = 1'b1;
            end_pos_next        = pos_inc;
            ctl_next.phase      = tsi_pkg::PH_ZERO;
          end else begin
            take_path = 1'b1;
          end
        end
        tsi_pkg::PH_ZERO: begin
          if (hex_mark) begin
            base_next      = tsi_pkg::RADIX_HEX;
            ctl_next.phase = tsi_pkg::PH_HEXMARK;
          end else begin
            take_path = 1'b1;
          end
        end
        tsi_pkg::PH_HEXMARK, tsi_pkg::PH_DIGITS: begin
          take_path = 1'b1;
        end
        default: begin
          take_path = 1'b0;
        end
      endcase
      if (take_path) begin
        base_next = wb;
        if (d < wb) begin
          if (!ctl.overflowed && wb >= 6'd2) begin
            if (fits) begin
              acc_next = prod[VALUE_BITS-1:0];
            end else begin
              ctl_next.overflowed = 1'b1;
            end
          end
          ctl_next.seen_digit = 1'b1;
          end_pos_next        = pos_inc;
          ctl_next.phase      = tsi_pkg::PH_DIGITS;
        end else begin
          ctl_next.phase = tsi_pkg::PH_DONE;
        end
      end
    end
  end

  assign top      = VALUE_BITS'(1) << (VALUE_BITS-1);
  assign end_wide = {{EW{1'b0}}, end_pos_next};

  always_comb begin
    val_s      = '0;
    res_end    = '0;
    res_status = tsi_pkg::ST_OK;
    if (tsi_pkg::radix_bad(base_next)) begin
      res_status = tsi_pkg::ST_BAD_RADIX;
    end else if (!ctl_next.seen_digit) begin
      res_status = tsi_pkg::ST_NO_DIGITS;
    end else begin
      res_end = end_wide[EW-1:0];
      if (ctl_next.overflowed) begin
        res_status = tsi_pkg::ST_RANGE;
        val_s      = ctl_next.negative ? top : top - VALUE_BITS'(1);
      end else begin
        val_s = ctl_next.negative ? '0 - acc_next : acc_next;
      end
    end
  end

  assign res_value = VW'(val_s);

endmodule

/* hdl/text_to_signed_integer.sv */
// Top level of the streaming text to signed integer parser.
//
//  channel   direction  beat carries
//  s_axis    in         tdata[7:0] character, tlast last
//  m_axis    out        tdata[63:0] value, [76:64] end_index, [78:77] status
//  cfg       in         cfg_data[5:0] radix
//
// One character is taken per cycle while the skid entry is empty; the whole parse
// step, a multiply by the radix with an add and a limit compare, settles between
// the state registers. A result is registered from its last character and waits
// in an output register backed by one skid entry, so input stalls only when both hold.
// Reset is synchronous and returns the radix to automatic and the parse to its start.
module text_to_signed_integer #(
  parameter int MAX_CHARS  = 4096,
  parameter int VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // character
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // value, end_index, status, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data        // radix
);

  localparam int PW  = $clog2(MAX_CHARS+1);
  localparam int RW  = tsi_pkg::VALUE_W + tsi_pkg::END_W + tsi_pkg::STATUS_W;
  localparam int PAD = 80 - RW;

  logic [tsi_pkg::RADIX_W-1:0] radix;
  tsi_pkg::ctl_t               ctl;
  tsi_pkg::ctl_t               ctl_next;
  logic [VALUE_BITS-1:0]       acc;
  logic [VALUE_BITS-1:0]       acc_next;
  logic [tsi_pkg::RADIX_W-1:0] base;
  logic [tsi_pkg::RADIX_W-1:0] base_next;
  logic [PW-1:0]               pos;
  logic [PW-1:0]               pos_next;
  logic [PW-1:0]               end_pos;
  logic [PW-1:0]               end_pos_next;
  logic [tsi_pkg::VALUE_W-1:0] res_value;
  logic [tsi_pkg::END_W-1:0]   res_end;
  logic [tsi_pkg::STATUS_W-1:0] res_status;
  logic [RW-1:0]               res_word;

  logic          out_valid;
  logic [RW-1:0] out_word;
  logic          skid_valid;
  logic [RW-1:0] skid_word;
  logic          accept;
  logic          push;
  logic          pop;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push          = accept && s_axis_tlast;
  assign pop           = out_valid && m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{PAD{1'b0}}, out_word};
  assign res_word      = {res_status, res_end, res_value};

  tsi_step #(
    .MAX_CHARS (MAX_CHARS),
    .VALUE_BITS(VALUE_BITS)
  ) u_step (
    .character   (s_axis_tdata),
    .radix       (radix),
    .ctl         (ctl),
    .acc         (acc),
    .base        (base),
    .pos         (pos),
    .end_pos     (end_pos),
    .ctl_next    (ctl_next),
    .acc_next    (acc_next),
    .base_next   (base_next),
    .pos_next    (pos_next),
    .end_pos_next(end_pos_next),
    .res_value   (res_value),
    .res_end     (res_end),
    .res_status  (res_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= tsi_pkg::RADIX_AUTO;
    end else if (cfg_valid && cfg_ready) begin
      radix <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl     <= tsi_pkg::CTL_RESET;
      acc     <= '0;
      base    <= tsi_pkg::RADIX_AUTO;
      pos     <= '0;
      end_pos <= '0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        ctl     <= tsi_pkg::CTL_RESET;
        acc     <= '0;
        base    <= tsi_pkg::RADIX_AUTO;
        pos     <= '0;
        end_pos <= '0;
      end else begin
        ctl     <= ctl_next;
        acc     <= acc_next;
        base    <= base_next;
        pos     <= pos_next;
        end_pos <= end_pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_word <= skid_word;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_word <= res_word;
      end else begin
        skid_word <= res_word;
      end
    end
  end

endmodule
